// ----- rtl/i2cmrt_pkg.sv -----
`timescale 1ns / 1ps
package i2cmrt_pkg;
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_BYTE  = 2'd3;

  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_QUARTER  = 2'd1;
  localparam logic [1:0] CFG_POLL     = 2'd2;

  localparam logic [1:0] DONE_NONE  = 2'd0;
  localparam logic [1:0] DONE_OK    = 2'd1;
  localparam logic [1:0] DONE_NACK  = 2'd2;

  localparam logic [6:0] DEV_ADDR_RST = 7'h32;
  localparam logic [7:0] QUARTER_RST  = 8'd2;
  localparam logic [7:0] POLL_RST     = 8'd12;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] reg_address;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_level;
  } in_word_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       need_byte;
    logic       busy_res;
    logic [1:0] done_status;
  } out_word_t;
endpackage

// ----- rtl/i2cmrt_in_if.sv -----
`timescale 1ns / 1ps
interface i2cmrt_in_if import i2cmrt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/i2cmrt_out_if.sv -----
`timescale 1ns / 1ps
interface i2cmrt_out_if import i2cmrt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/i2cmrt_fifo.sv -----
`timescale 1ns / 1ps
module i2cmrt_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [Width-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [Width-1:0] rd_data
);
  // two-entry queue, full throughput
  logic [Width-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- rtl/i2cmrt_engine.sv -----
`timescale 1ns / 1ps
module i2cmrt_engine import i2cmrt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_word_t  cmd,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res
);
  localparam logic [3:0] PH_IDLE = 4'd0, PH_START = 4'd1, PH_SEND = 4'd2,
    PH_ACK = 4'd3, PH_POLL = 4'd4, PH_WAIT = 4'd5, PH_RECV = 4'd6,
    PH_MACK = 4'd7, PH_STOP = 4'd8;
  localparam logic [1:0] ST_ADDR_W = 2'd0, ST_REG = 2'd1, ST_ADDR_R = 2'd2,
    ST_DATA = 2'd3;

  logic [6:0] dev_r;
  logic [7:0] qtr_r, lim_r;
  logic [3:0] phase_r, phase_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt, left_r, left_nxt, tick_r, tick_nxt;
  logic [7:0] poll_r, poll_nxt, sreg_r, sreg_nxt;
  logic       rd_r, rd_nxt, scl_r, scl_nxt, sda_r, sda_nxt, fail_r, fail_nxt;
  logic [1:0] qt_r, qt_nxt, stage_r, stage_nxt;
  logic       ov, step;
  logic [7:0] ob;
  logic [1:0] od;
  logic [7:0] qlen;

  // output register; take a word when empty or draining
  assign cmd_ready = !res_valid || res_ready;
  assign step = cmd_valid && cmd_ready;
  assign qlen = (qtr_r == 8'd0) ? 8'd1 : qtr_r;

  always_comb begin
    phase_nxt = phase_r; bit_nxt = bit_r; shift_nxt = shift_r;
    left_nxt = left_r; tick_nxt = tick_r; poll_nxt = poll_r;
    sreg_nxt = sreg_r; rd_nxt = rd_r; scl_nxt = scl_r; sda_nxt = sda_r;
    fail_nxt = fail_r; qt_nxt = qt_r; stage_nxt = stage_r;
    ov = 1'b0; ob = 8'd0; od = DONE_NONE;
    case (cmd.mode)
      MODE_TICK: begin
        if (phase_r == PH_POLL) begin
          if (!cmd.sda_level) begin
            scl_nxt = 1'b0;
            qt_nxt = 2'd0; tick_nxt = 8'd0; bit_nxt = 3'd0;
            case (stage_r)
              ST_ADDR_W: begin
                stage_nxt = ST_REG; shift_nxt = sreg_r; phase_nxt = PH_SEND;
              end
              ST_REG: begin
                if (left_r == 8'd0) phase_nxt = PH_STOP;
                else if (rd_r) begin
                  stage_nxt = ST_ADDR_R; phase_nxt = PH_START;
                end else phase_nxt = PH_WAIT;
              end
              ST_ADDR_R: begin
                shift_nxt = 8'd0; phase_nxt = PH_RECV;
              end
              default: begin
                left_nxt = left_r - 8'd1;
                phase_nxt = (left_r == 8'd1) ? PH_STOP : PH_WAIT;
              end
            endcase
          end else if (poll_r >= lim_r) begin
            fail_nxt = 1'b1; phase_nxt = PH_STOP;
            qt_nxt = 2'd0; tick_nxt = 8'd0; bit_nxt = 3'd0;
          end else poll_nxt = poll_r + 8'd1;
        end else if (phase_r != PH_IDLE && phase_r != PH_WAIT) begin
          if ({1'b0, tick_r} + 9'd1 >= {1'b0, qlen}) begin
            tick_nxt = 8'd0;
            if (phase_r == PH_RECV && qt_r == 2'd1)
              shift_nxt = {shift_r[6:0], cmd.sda_level};
            if (qt_r != 2'd3) qt_nxt = qt_r + 2'd1;
            else begin
              qt_nxt = 2'd0;
              case (phase_r)
                PH_START: begin
                  shift_nxt = {dev_r, stage_r == ST_ADDR_R};
                  phase_nxt = PH_SEND; bit_nxt = 3'd0;
                end
                PH_SEND: begin
                  shift_nxt = {shift_r[6:0], 1'b0};
                  if (bit_r == 3'd7) begin
                    phase_nxt = PH_ACK; bit_nxt = 3'd0;
                  end else bit_nxt = bit_r + 3'd1;
                end
                PH_ACK: begin
                  phase_nxt = PH_POLL; poll_nxt = 8'd0;
                end
                PH_RECV: begin
                  if (bit_r == 3'd7) begin
                    ov = 1'b1; ob = shift_nxt;
                    left_nxt = left_r - 8'd1;
                    phase_nxt = PH_MACK; bit_nxt = 3'd0;
                  end else bit_nxt = bit_r + 3'd1;
                end
                PH_MACK: begin
                  bit_nxt = 3'd0;
                  if (left_r == 8'd0) phase_nxt = PH_STOP;
                  else begin
                    shift_nxt = 8'd0; phase_nxt = PH_RECV;
                  end
                end
                PH_STOP: begin
                  phase_nxt = PH_IDLE;
                  od = fail_r ? DONE_NACK : DONE_OK;
                end
                default: ;
              endcase
            end
          end else tick_nxt = tick_r + 8'd1;
        end
      end
      MODE_BYTE: begin
        if (phase_r == PH_WAIT) begin
          shift_nxt = cmd.write_byte; stage_nxt = ST_DATA;
          phase_nxt = PH_SEND; qt_nxt = 2'd0; tick_nxt = 8'd0; bit_nxt = 3'd0;
        end
      end
      default: begin
        if (phase_r == PH_IDLE) begin
          sreg_nxt = cmd.reg_address; left_nxt = cmd.byte_count;
          rd_nxt = (cmd.mode == MODE_READ); stage_nxt = ST_ADDR_W;
          fail_nxt = 1'b0; poll_nxt = 8'd0; shift_nxt = 8'd0;
          phase_nxt = PH_START; qt_nxt = 2'd0; tick_nxt = 8'd0; bit_nxt = 3'd0;
        end
      end
    endcase
    // line levels follow the new phase and quarter
    case (phase_nxt)
      PH_START: begin
        case (qt_nxt)
          2'd0: sda_nxt = 1'b1;
          2'd1: begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
          2'd2: begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
          default: begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        endcase
      end
      PH_SEND: begin
        if (qt_nxt == 2'd0) scl_nxt = 1'b0;
        else if (qt_nxt == 2'd1) begin
          scl_nxt = 1'b0; sda_nxt = shift_nxt[7];
        end else scl_nxt = 1'b1;
      end
      PH_ACK: begin
        if (!qt_nxt[1]) begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        else scl_nxt = 1'b1;
      end
      PH_RECV: begin
        if (qt_nxt == 2'd0) begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
        else if (qt_nxt != 2'd3) scl_nxt = 1'b1;
        else scl_nxt = 1'b0;
      end
      PH_MACK: begin
        if (!qt_nxt[1]) begin
          scl_nxt = 1'b0; sda_nxt = (left_nxt == 8'd0);
        end else scl_nxt = 1'b1;
      end
      PH_STOP: begin
        if (qt_nxt == 2'd0) begin scl_nxt = 1'b0; sda_nxt = 1'b0; end
        else if (qt_nxt == 2'd1) begin scl_nxt = 1'b1; sda_nxt = 1'b0; end
        else begin scl_nxt = 1'b1; sda_nxt = 1'b1; end
      end
      PH_WAIT: begin scl_nxt = 1'b0; sda_nxt = 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= DEV_ADDR_RST; qtr_r <= QUARTER_RST; lim_r <= POLL_RST;
      phase_r <= PH_IDLE; bit_r <= 3'd0; shift_r <= 8'd0; left_r <= 8'd0;
      tick_r <= 8'd0; poll_r <= 8'd0; sreg_r <= 8'd0; rd_r <= 1'b0;
      scl_r <= 1'b1; sda_r <= 1'b1; fail_r <= 1'b0; qt_r <= 2'd0;
      stage_r <= ST_ADDR_W; res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DEV_ADDR: dev_r <= cfg_wdata[6:0];
          CFG_QUARTER:  qtr_r <= cfg_wdata;
          CFG_POLL:     lim_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (res_ready) res_valid <= 1'b0;
      if (step) begin
        phase_r <= phase_nxt; bit_r <= bit_nxt; shift_r <= shift_nxt;
        left_r <= left_nxt; tick_r <= tick_nxt; poll_r <= poll_nxt;
        sreg_r <= sreg_nxt; rd_r <= rd_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
        fail_r <= fail_nxt; qt_r <= qt_nxt; stage_r <= stage_nxt;
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.scl_release <= scl_nxt;
      res.sda_release <= sda_nxt;
      res.read_valid  <= ov;
      res.read_byte   <= ob;
      res.need_byte   <= (phase_nxt == PH_WAIT);
      res.busy_res    <= (phase_nxt != PH_IDLE);
      res.done_status <= od;
    end
  end
endmodule

// ----- rtl/i2c_master_register_transfer_top.sv -----
`timescale 1ns / 1ps
// I2C register-transfer master. Each input word (tick, begin write, begin
// read, next write byte) yields exactly one result word with the SCL/SDA
// release levels and status. Words flow at one per cycle while the sink is
// ready: a two-entry queue decouples input acceptance from the bus engine,
// and the engine's output register takes a word when empty or as it drains.
// Words pass the queue and engine registers in turn. Bus timing is counted in
// tick words only, quarter_bit_ticks per quarter bit; configuration writes
// take effect on the next cycle and should be made while the block is idle.
module i2c_master_register_transfer_top import i2cmrt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [7:0] cfg_wdata,
  i2cmrt_in_if.sink    in_ch,
  i2cmrt_out_if.source out_ch
);
  logic     q_valid, q_ready;
  in_word_t q_data;

  // front: queue the incoming words
  i2cmrt_fifo #(.Width($bits(in_word_t))) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_ch.valid), .wr_ready(in_ch.ready), .wr_data(in_ch.data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  // back: advance the bus state machine
  i2cmrt_engine u_engine (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_data),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
  );
endmodule

// ----- rtl/i2cmrt_checker.sv -----
`timescale 1ns / 1ps
module i2cmrt_checker import i2cmrt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_status != DONE_NONE |-> !out_data.busy_res)
    else $error("done while busy");
  a_need: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.need_byte |-> out_data.busy_res && !out_data.scl_release)
    else $error("need_byte outside wait");
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_valid |-> out_data.read_byte == 8'd0)
    else $error("read_byte without read_valid");
endmodule

bind i2c_master_register_transfer_top i2cmrt_checker u_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ----- tb/i2c_master_register_transfer_top_tb.sv -----
`timescale 1ns / 1ps
module i2c_master_register_transfer_top_tb;
  import i2cmrt_pkg::*;

  // Bus engine phases and transfer stages of the prediction.
  typedef enum logic [3:0] {
    P_IDLE, P_START, P_SEND, P_ACK, P_POLL, P_WAIT, P_RECV, P_MACK, P_STOP
  } bus_phase_t;
  typedef enum logic [1:0] {S_ADDR_W, S_REG, S_ADDR_R, S_DATA} xfer_stage_t;

  localparam int STALL_LIMIT = 20000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  i2cmrt_in_if  in_ch ();
  i2cmrt_out_if out_ch ();

  i2c_master_register_transfer_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor state: one copy of the engine, mirrored in words accepted.
  logic [6:0]  m_dev;
  logic [7:0]  m_qtr;
  logic [7:0]  m_poll_lim;
  bus_phase_t  m_phase;
  xfer_stage_t m_stage;
  logic [3:0]  m_bit;
  logic [7:0]  m_shift, m_left, m_ticks, m_polls, m_reg;
  logic [1:0]  m_quarter;
  logic        m_rd, m_scl, m_sda, m_failed;
  logic        o_valid;
  logic [7:0]  o_byte;
  logic [1:0]  o_done;

  out_word_t expected_words[$];
  int        errors;
  int        words_sent;
  int        reads_seen, ok_seen, nack_seen;
  int        idle_cycles;
  bit        stall_heavy;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic void drive_levels();
    case (m_phase)
      P_START: begin
        if (m_quarter == 0) m_sda = 1;
        else if (m_quarter == 1) begin m_scl = 1; m_sda = 1; end
        else if (m_quarter == 2) begin m_scl = 1; m_sda = 0; end
        else begin m_scl = 0; m_sda = 0; end
      end
      P_SEND: begin
        if (m_quarter == 0) m_scl = 0;
        else if (m_quarter == 1) begin m_scl = 0; m_sda = m_shift[7]; end
        else m_scl = 1;
      end
      P_ACK: begin
        if (m_quarter < 2) begin m_scl = 0; m_sda = 1; end else m_scl = 1;
      end
      P_RECV: begin
        if (m_quarter == 0) begin m_scl = 0; m_sda = 1; end
        else if (m_quarter < 3) m_scl = 1;
        else m_scl = 0;
      end
      P_MACK: begin
        if (m_quarter < 2) begin m_scl = 0; m_sda = (m_left == 0); end
        else m_scl = 1;
      end
      P_STOP: begin
        if (m_quarter == 0) begin m_scl = 0; m_sda = 0; end
        else if (m_quarter == 1) begin m_scl = 1; m_sda = 0; end
        else begin m_scl = 1; m_sda = 1; end
      end
      P_WAIT: begin m_scl = 0; m_sda = 1; end
      default: ;
    endcase
  endfunction

  function automatic void go_phase(input bus_phase_t p);
    m_phase = p;
    m_quarter = 0;
    m_ticks = 0;
    m_bit = 0;
    drive_levels();
  endfunction

  function automatic void acked();
    case (m_stage)
      S_ADDR_W: begin m_stage = S_REG; m_shift = m_reg; go_phase(P_SEND); end
      S_REG: begin
        if (m_left == 0) go_phase(P_STOP);
        else if (m_rd) begin m_stage = S_ADDR_R; go_phase(P_START); end
        else go_phase(P_WAIT);
      end
      S_ADDR_R: begin m_shift = 0; go_phase(P_RECV); end
      default: begin
        m_left = m_left - 1;
        if (m_left == 0) go_phase(P_STOP); else go_phase(P_WAIT);
      end
    endcase
  endfunction

  function automatic void quarter_done(input logic sda);
    if (m_phase == P_RECV && m_quarter == 1) m_shift = {m_shift[6:0], sda};
    if (m_quarter < 3) begin
      m_quarter++;
      drive_levels();
      return;
    end
    case (m_phase)
      P_START: begin
        m_shift = {m_dev, m_stage == S_ADDR_R};
        go_phase(P_SEND);
      end
      P_SEND: begin
        m_shift = m_shift << 1;
        if (m_bit >= 7) go_phase(P_ACK);
        else begin m_bit++; m_quarter = 0; drive_levels(); end
      end
      P_ACK: begin m_phase = P_POLL; m_polls = 0; end
      P_RECV: begin
        if (m_bit >= 7) begin
          o_valid = 1;
          o_byte = m_shift;
          m_left = m_left - 1;
          go_phase(P_MACK);
        end else begin m_bit++; m_quarter = 0; drive_levels(); end
      end
      P_MACK: begin
        if (m_left == 0) go_phase(P_STOP);
        else begin m_shift = 0; go_phase(P_RECV); end
      end
      P_STOP: begin
        m_phase = P_IDLE;
        m_quarter = 0;
        o_done = m_failed ? DONE_NACK : DONE_OK;
      end
      default: ;
    endcase
  endfunction

  // Advance the predicted engine by one word and queue the result it yields.
  function automatic void predict_bus_word(input in_word_t w);
    out_word_t r;
    o_valid = 0; o_byte = 0; o_done = DONE_NONE;
    if (w.mode == MODE_TICK) begin
      if (m_phase == P_POLL) begin
        if (!w.sda_level) begin m_scl = 0; acked(); end
        else if (m_polls >= m_poll_lim) begin m_failed = 1; go_phase(P_STOP); end
        else m_polls++;
      end else if (m_phase != P_IDLE && m_phase != P_WAIT) begin
        if (int'(m_ticks) + 1 >= ((m_qtr == 0) ? 1 : int'(m_qtr))) begin
          m_ticks = 0;
          quarter_done(w.sda_level);
        end else m_ticks++;
      end
    end else if (w.mode == MODE_BYTE) begin
      if (m_phase == P_WAIT) begin
        m_shift = w.write_byte;
        m_stage = S_DATA;
        go_phase(P_SEND);
      end
    end else if (m_phase == P_IDLE) begin
      m_reg = w.reg_address;
      m_left = w.byte_count;
      m_rd = (w.mode == MODE_READ);
      m_stage = S_ADDR_W;
      m_failed = 0;
      m_polls = 0;
      m_shift = 0;
      go_phase(P_START);
    end
    r.scl_release = m_scl;
    r.sda_release = m_sda;
    r.read_valid  = o_valid;
    r.read_byte   = o_byte;
    r.need_byte   = (m_phase == P_WAIT);
    r.busy_res    = (m_phase != P_IDLE);
    r.done_status = o_done;
    expected_words.push_back(r);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    return $urandom_range(0, 2);
  endfunction

  // Present a word at a falling edge after any stall_heavy gap, hold it until
  // accepted, predict its result; valid stays high so words follow back to back.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = stall_heavy ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_bus_word(w);
    words_sent++;
  endtask

  // Drop valid at the next falling edge when no word follows.
  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_tick(input logic sda);
    in_word_t w;
    w = '0;
    w.mode = MODE_TICK;
    w.sda_level = sda;
    w.reg_address = $urandom;
    w.byte_count = $urandom;
    w.write_byte = $urandom;
    send_word(w);
  endtask

  task automatic send_begin(input logic [1:0] mode, input logic [7:0] regaddr,
                            input logic [7:0] count);
    in_word_t w;
    w.mode = mode;
    w.reg_address = regaddr;
    w.byte_count = count;
    w.write_byte = $urandom;
    w.sda_level = $urandom;
    send_word(w);
  endtask

  task automatic send_data_byte(input logic [7:0] b);
    in_word_t w;
    w.mode = MODE_BYTE;
    w.reg_address = $urandom;
    w.byte_count = $urandom;
    w.write_byte = b;
    w.sda_level = $urandom;
    send_word(w);
  endtask

  // Drain pending results, wait out the pipeline, then write a register.
  task automatic write_cfg(input logic [1:0] idx, input logic [7:0] val);
    idle_input();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEV_ADDR: m_dev = val[6:0];
      CFG_QUARTER:  m_qtr = val;
      default:      m_poll_lim = val;
    endcase
  endtask

  // Tick the engine until it is idle or asks for a byte; the device model
  // acks with probability ack_pct and drives random read data.
  task automatic run_bus(input int ack_pct);
    int guard;
    guard = 0;
    while (m_phase != P_IDLE && m_phase != P_WAIT && guard < 40000) begin
      if (m_phase == P_POLL) send_tick($urandom_range(0, 99) >= ack_pct);
      else send_tick($urandom);
      guard++;
    end
  endtask

  task automatic do_transfer(input logic is_read, input logic [7:0] count,
                             input int ack_pct);
    send_begin(is_read ? MODE_READ : MODE_WRITE, $urandom, count);
    run_bus(ack_pct);
    while (m_phase == P_WAIT) begin
      if ($urandom_range(0, 3) == 0) send_tick($urandom);
      send_data_byte($urandom);
      run_bus(ack_pct);
    end
  endtask

  task automatic test_directed();
    stall_heavy = 0;
    // Full-scale write with immediate acks, then a mode-3 word while idle.
    send_begin(MODE_WRITE, 8'hff, 8'd1);
    send_begin(MODE_READ, 8'h00, 8'd3);
    run_bus(100);
    send_data_byte(8'hff);
    run_bus(100);
    send_data_byte(8'h00);
    send_tick(1'b1);
    // Zero-count transfer finishes after the register byte.
    send_begin(MODE_READ, 8'h5a, 8'd0);
    run_bus(100);
    // Read of two bytes exercises ack and final nack.
    send_begin(MODE_READ, 8'ha5, 8'd2);
    run_bus(100);
    // Never ack: abort with stop.
    send_begin(MODE_WRITE, 8'h11, 8'd4);
    run_bus(0);
  endtask

  task automatic test_config_extremes();
    write_cfg(CFG_DEV_ADDR, 8'h7f);
    write_cfg(CFG_QUARTER, 8'd1);
    write_cfg(CFG_POLL, 8'd0);
    do_transfer(1'b0, 8'd2, 60);
    do_transfer(1'b1, 8'd2, 60);
    write_cfg(CFG_DEV_ADDR, 8'h00);
    write_cfg(CFG_QUARTER, 8'd0);
    write_cfg(CFG_POLL, 8'd255);
    do_transfer(1'b1, 8'd1, 40);
    do_transfer(1'b0, 8'd1, 1);
    write_cfg(CFG_QUARTER, 8'd3);
    write_cfg(CFG_POLL, 8'd1);
    do_transfer(1'b0, 8'd1, 100);
    write_cfg(CFG_QUARTER, 8'd1);
  endtask

  task automatic test_random();
    int start;
    start = words_sent;
    while (words_sent - start < 300) begin
      stall_heavy = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // Noise: a stray word of any mode, plus one tick.
        send_begin($urandom, $urandom, $urandom);
        send_tick($urandom);
      end else begin
        if ($urandom_range(0, 5) == 0) begin
          write_cfg(CFG_DEV_ADDR, $urandom);
          write_cfg(CFG_QUARTER, $urandom_range(0, 2));
          write_cfg(CFG_POLL, $urandom_range(0, 6));
        end
        do_transfer($urandom, $urandom_range(0, 3), $urandom_range(0, 4) == 0 ? 30 : 85);
      end
    end
  endtask

  // Result checker: pop the oldest expectation on every accepted word.
  initial begin
    out_word_t got, want;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", got, 0);
        end else begin
          want = expected_words.pop_front();
          if (got.scl_release !== want.scl_release)
            report_mismatch("scl_release", got.scl_release, want.scl_release);
          if (got.sda_release !== want.sda_release)
            report_mismatch("sda_release", got.sda_release, want.sda_release);
          if (got.read_valid !== want.read_valid)
            report_mismatch("read_valid", got.read_valid, want.read_valid);
          if (got.read_byte !== want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
          if (got.need_byte !== want.need_byte)
            report_mismatch("need_byte", got.need_byte, want.need_byte);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.done_status !== want.done_status)
            report_mismatch("done_status", got.done_status, want.done_status);
          if (want.read_valid) reads_seen++;
          if (want.done_status == DONE_OK) ok_seen++;
          if (want.done_status == DONE_NACK) nack_seen++;
        end
      end
    end
  end

  // Drive the sink ready at falling edges: stretches of full rate between stalls.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; words_sent = 0; reads_seen = 0; ok_seen = 0; nack_seen = 0;
    m_dev = DEV_ADDR_RST; m_qtr = QUARTER_RST; m_poll_lim = POLL_RST;
    m_phase = P_IDLE; m_stage = S_ADDR_W; m_bit = 0; m_shift = 0; m_left = 0;
    m_ticks = 0; m_polls = 0; m_reg = 0; m_quarter = 0; m_rd = 0;
    m_scl = 1; m_sda = 1; m_failed = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = CFG_DEV_ADDR; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_random();

    // Wait out outstanding results, then the pipeline latency.
    idle_input();
    while (expected_words.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("sent %0d words; %0d bytes read, %0d transfers ok, %0d aborted",
             words_sent, reads_seen, ok_seen, nack_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
